/* hw/rtl/lmr_pkg.sv */
// lmr_pkg: shared codes, defaults, step tables and neighbor status struct
// for the layered maze router; no dependencies
package lmr_pkg;

    localparam int GRID_DIM_DEF   = 128;
    localparam int MAX_LAYERS_DEF = 4;
    localparam int EPW            = 8;   // visit mark width

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_ROUTE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_PATH = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LAYER_COUNT = 2'd2;

    localparam logic [7:0] GRID_WIDTH_RST  = 8'd128;
    localparam logic [7:0] GRID_HEIGHT_RST = 8'd128;
    localparam logic [2:0] LAYER_COUNT_RST = 3'd1;

    typedef struct packed {
        logic done;  // all candidates of the current cell tried
        logic ok;    // candidate lies in the grid and is not the current cell
        logic goal;  // candidate is at the goal column and row
    } nbr_t;

    // order: +x, -x, +y, -y, +x+y, +x-y, -x+y, -x-y
    function automatic logic signed [1:0] step_dx(input logic [2:0] d);
        case (d)
            3'd0, 3'd4, 3'd5: step_dx = 2'sd1;
            3'd1, 3'd6, 3'd7: step_dx = -2'sd1;
            default:          step_dx = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] d);
        case (d)
            3'd2, 3'd4, 3'd6: step_dy = 2'sd1;
            3'd3, 3'd5, 3'd7: step_dy = -2'sd1;
            default:          step_dy = 2'sd0;
        endcase
    endfunction

endpackage

/* hw/rtl/layered_maze_router_unit.sv */
// layered_maze_router_unit: top level, command sequencer over the cell memory
// and the list memory; uses lmr_pkg, lmr_ram and lmr_nbr
//
// Breadth-first maze router over a GRID_DIM x GRID_DIM x MAX_LAYERS cell
// memory. After reset the block sweeps the whole cell memory before it takes
// an item. A route that finds the visit marks used up (the 256th searching
// route after reset, then every 255th) first repeats that sweep, keeping the
// obstacles. An obstacle write reads the cell, then writes it, then loads the
// result; a path read reads the path list, captures the cell, then loads the
// result. An item answered at once goes straight to the result load: a route
// out of the grid, a route whose start is its goal, a read with no path or
// beyond the path, and the unused command. A searching route reads and
// evaluates the start cell on each layer in use to seed the queue, then for
// each dequeued cell takes its candidates in turn: one outside the grid or on
// its own layer is only checked, any other is read and evaluated. The search
// ends when the queue runs empty or, on a find, walks the path back one cell
// read at a time, then the result is loaded. One item is in work at a time;
// the result register lets the next item in while the previous result waits.
module layered_maze_router_unit #(
    parameter int GRID_DIM = lmr_pkg::GRID_DIM_DEF,
    parameter int MAX_LAYERS = lmr_pkg::MAX_LAYERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [1:0]  s_layer_sel,
    input  logic [6:0]  s_cell_x,
    input  logic [6:0]  s_cell_y,
    input  logic        s_blocked,
    input  logic [6:0]  s_goal_x,
    input  logic [6:0]  s_goal_y,
    input  logic [15:0] s_path_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [16:0] m_path_length,
    output logic [6:0]  m_out_x,
    output logic [6:0]  m_out_y,
    output logic [1:0]  m_out_layer
);

    localparam int CW = $clog2(GRID_DIM);
    localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int AW = LW + 2 * CW;
    localparam int PCW = AW + 1;
    localparam int LCW = $clog2(MAX_LAYERS + 1);
    localparam int CANDW = $clog2(8 + MAX_LAYERS + 1);
    localparam int EPW = lmr_pkg::EPW;
    localparam int EW = 1 + EPW + PCW;
    localparam int CMPW = (CW + 1 > 7) ? CW + 1 : 7;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_OBS_WR, S_SEED_RD, S_SEED_EV, S_POP_RD, S_POP_EV,
        S_NB_RD, S_NB_EV, S_WALK_RD, S_WALK_EV, S_PATH_EV, S_DONE
    } state_t;

    state_t          state_reg;
    logic [7:0]      cfg_w_reg, cfg_h_reg;
    logic [2:0]      cfg_l_reg;
    logic [CW:0]     w_eff, h_eff;
    logic [LCW-1:0]  l_eff;

    logic [PCW-1:0]  sweep_reg;
    logic            keep_reg;
    logic [EPW-1:0]  epoch_reg;
    logic [PCW-1:0]  path_count_reg;
    logic [PCW-1:0]  head_reg, tail_reg;
    logic [LCW-1:0]  sl_reg;
    logic [CANDW-1:0] cand_reg;
    logic [AW-1:0]   cur_reg, op_addr_reg, walk_reg, k_reg;
    logic            goal_reg, blk_reg;
    logic [CW-1:0]   sx_reg, sy_reg, gx_reg, gy_reg;
    logic [1:0]      res_status_reg;
    logic [6:0]      res_x_reg, res_y_reg;
    logic [1:0]      res_l_reg;
    logic            m_valid_reg;
    logic [1:0]      m_status_reg;
    logic [16:0]     m_len_reg;
    logic [6:0]      m_x_reg, m_y_reg;
    logic [1:0]      m_l_reg;

    logic            c_we, c_re, l_we, l_re;
    logic [AW-1:0]   c_waddr, c_raddr, l_waddr, l_raddr;
    logic [EW-1:0]   c_wdata, c_rdata;
    logic [AW-1:0]   l_wdata, l_rdata;
    logic            rd_obs;
    logic [EPW-1:0]  rd_epoch;
    logic [PCW-1:0]  rd_parent;
    logic            claim;

    lmr_pkg::nbr_t   nb;
    logic [AW-1:0]   nb_addr;

    logic            wr_ok, rt_oob, rt_same, rd_ok, rd_range;
    logic [AW-1:0]   wr_addr, goal0_addr, seed_addr, path_addr;
    logic [PCW-1:0]  path_off;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= lmr_pkg::GRID_WIDTH_RST;
            cfg_h_reg <= lmr_pkg::GRID_HEIGHT_RST;
            cfg_l_reg <= lmr_pkg::LAYER_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lmr_pkg::CFG_GRID_WIDTH:  cfg_w_reg <= cfg_wdata;
                lmr_pkg::CFG_GRID_HEIGHT: cfg_h_reg <= cfg_wdata;
                lmr_pkg::CFG_LAYER_COUNT: cfg_l_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = (cfg_w_reg == 8'd0) ? (CW+1)'(1) :
                (32'(cfg_w_reg) > GRID_DIM) ? (CW+1)'(GRID_DIM) : (CW+1)'(cfg_w_reg);
        h_eff = (cfg_h_reg == 8'd0) ? (CW+1)'(1) :
                (32'(cfg_h_reg) > GRID_DIM) ? (CW+1)'(GRID_DIM) : (CW+1)'(cfg_h_reg);
        l_eff = (cfg_l_reg == 3'd0) ? LCW'(1) :
                (32'(cfg_l_reg) > MAX_LAYERS) ? LCW'(MAX_LAYERS) : LCW'(cfg_l_reg);
    end

    lmr_ram #(.WIDTH(EW), .ADDR_W(AW)) u_cell_mem (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
    );

    // frontier queue during the search, path list afterwards
    lmr_ram #(.WIDTH(AW), .ADDR_W(AW)) u_list_mem (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
    );

    lmr_nbr #(.CW(CW), .LW(LW), .LCW(LCW), .CANDW(CANDW)) u_nbr (
        .cur_x(cur_reg[CW-1:0]), .cur_y(cur_reg[2*CW-1:CW]), .cur_l(cur_reg[AW-1:2*CW]),
        .goal_x(gx_reg), .goal_y(gy_reg), .cand(cand_reg),
        .w_eff(w_eff), .h_eff(h_eff), .l_eff(l_eff), .nb(nb), .nb_addr(nb_addr)
    );

    always_comb begin
        rd_obs    = c_rdata[EW-1];
        rd_epoch  = c_rdata[EW-2 -: EPW];
        rd_parent = c_rdata[PCW-1:0];
        // a cell is visited when it carries the mark of the current route
        claim     = (rd_epoch != epoch_reg) && (!rd_obs || goal_reg);

        wr_ok   = (32'(s_layer_sel) < MAX_LAYERS) && (32'(s_cell_x) < GRID_DIM)
                  && (32'(s_cell_y) < GRID_DIM);
        wr_addr = {LW'(s_layer_sel), CW'(s_cell_y), CW'(s_cell_x)};
        rt_oob  = (CMPW'(s_cell_x) >= CMPW'(w_eff)) || (CMPW'(s_cell_y) >= CMPW'(h_eff))
                  || (CMPW'(s_goal_x) >= CMPW'(w_eff)) || (CMPW'(s_goal_y) >= CMPW'(h_eff));
        rt_same = (s_cell_x == s_goal_x) && (s_cell_y == s_goal_y);
        goal0_addr = {LW'(0), CW'(s_goal_y), CW'(s_goal_x)};
        rd_ok    = (path_count_reg != '0);
        rd_range = (32'(s_path_index) >= 32'(path_count_reg));
        // path list holds the path goal first
        path_off  = path_count_reg - PCW'(1) - PCW'(s_path_index);
        path_addr = path_off[AW-1:0];
        seed_addr = {LW'(sl_reg), sy_reg, sx_reg};
    end

    // memory port control
    always_comb begin
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_re = 1'b0; c_raddr = '0;
        l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_re = 1'b0; l_raddr = '0;
        case (state_reg)
            S_CLEAR: begin
                c_re    = !sweep_reg[AW];
                c_raddr = sweep_reg[AW-1:0];
                c_we    = (sweep_reg != '0);
                c_waddr = AW'(sweep_reg - PCW'(1));
                c_wdata = {keep_reg & rd_obs, EPW'(0), PCW'(0)};
            end
            S_IDLE: begin
                if (s_valid) begin
                    case (s_cmd)
                        lmr_pkg::CMD_WRITE: begin
                            c_re    = wr_ok;
                            c_raddr = wr_addr;
                        end
                        lmr_pkg::CMD_ROUTE: begin
                            l_we    = !rt_oob && rt_same;
                            l_waddr = '0;
                            l_wdata = goal0_addr;
                        end
                        lmr_pkg::CMD_READ: begin
                            l_re    = rd_ok && !rd_range;
                            l_raddr = path_addr;
                        end
                        default: ;
                    endcase
                end
            end
            S_OBS_WR: begin
                c_we    = 1'b1;
                c_waddr = op_addr_reg;
                c_wdata = {blk_reg, rd_epoch, rd_parent};
            end
            S_SEED_RD: begin
                c_re    = (32'(sl_reg) < 32'(l_eff));
                c_raddr = seed_addr;
            end
            S_SEED_EV: begin
                c_we    = !rd_obs;
                c_waddr = op_addr_reg;
                c_wdata = {rd_obs, epoch_reg, PCW'(0)};
                l_we    = !rd_obs;
                l_waddr = tail_reg[AW-1:0];
                l_wdata = op_addr_reg;
            end
            S_POP_RD: begin
                l_re    = (head_reg != tail_reg);
                l_raddr = head_reg[AW-1:0];
            end
            S_NB_RD: begin
                c_re    = !nb.done && nb.ok;
                c_raddr = nb_addr;
            end
            S_NB_EV: begin
                c_we    = claim;
                c_waddr = op_addr_reg;
                c_wdata = {rd_obs, epoch_reg, PCW'(cur_reg) + PCW'(1)};
                l_we    = claim && !goal_reg;
                l_waddr = tail_reg[AW-1:0];
                l_wdata = op_addr_reg;
            end
            S_WALK_RD: begin
                l_we    = 1'b1;
                l_waddr = k_reg;
                l_wdata = walk_reg;
                c_re    = 1'b1;
                c_raddr = walk_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            sweep_reg      <= '0;
            keep_reg       <= 1'b0;
            epoch_reg      <= '0;
            path_count_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            sl_reg         <= '0;
            cand_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // the result load below owns m_valid_reg in the done state
            if (m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    sweep_reg <= sweep_reg + PCW'(1);
                    if (sweep_reg[AW]) begin
                        sweep_reg <= '0;
                        if (keep_reg) begin
                            epoch_reg <= EPW'(1);
                            state_reg <= S_SEED_RD;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        res_status_reg <= lmr_pkg::STATUS_OK;
                        res_x_reg      <= '0;
                        res_y_reg      <= '0;
                        res_l_reg      <= '0;
                        state_reg      <= S_DONE;
                        case (s_cmd)
                            lmr_pkg::CMD_WRITE: begin
                                op_addr_reg <= wr_addr;
                                blk_reg     <= s_blocked;
                                if (wr_ok) begin
                                    state_reg <= S_OBS_WR;
                                end
                            end
                            lmr_pkg::CMD_ROUTE: begin
                                path_count_reg <= '0;
                                sx_reg   <= CW'(s_cell_x);
                                sy_reg   <= CW'(s_cell_y);
                                gx_reg   <= CW'(s_goal_x);
                                gy_reg   <= CW'(s_goal_y);
                                head_reg <= '0;
                                tail_reg <= '0;
                                sl_reg   <= '0;
                                if (rt_oob) begin
                                    res_status_reg <= lmr_pkg::STATUS_NO_PATH;
                                end else if (rt_same) begin
                                    path_count_reg <= PCW'(1);
                                end else if (epoch_reg == '1) begin
                                    // marks exhausted: recycle them first
                                    keep_reg  <= 1'b1;
                                    sweep_reg <= '0;
                                    state_reg <= S_CLEAR;
                                end else begin
                                    epoch_reg <= epoch_reg + EPW'(1);
                                    state_reg <= S_SEED_RD;
                                end
                            end
                            lmr_pkg::CMD_READ: begin
                                if (!rd_ok) begin
                                    res_status_reg <= lmr_pkg::STATUS_NO_PATH;
                                end else if (rd_range) begin
                                    res_status_reg <= lmr_pkg::STATUS_RANGE;
                                end else begin
                                    state_reg <= S_PATH_EV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_OBS_WR: begin
                    state_reg <= S_DONE;
                end
                S_SEED_RD: begin
                    op_addr_reg <= seed_addr;
                    if (32'(sl_reg) < 32'(l_eff)) begin
                        state_reg <= S_SEED_EV;
                    end else begin
                        state_reg <= S_POP_RD;
                    end
                end
                S_SEED_EV: begin
                    sl_reg <= sl_reg + LCW'(1);
                    if (!rd_obs) begin
                        tail_reg <= tail_reg + PCW'(1);
                    end
                    state_reg <= S_SEED_RD;
                end
                S_POP_RD: begin
                    if (head_reg == tail_reg) begin
                        res_status_reg <= lmr_pkg::STATUS_NO_PATH;
                        state_reg      <= S_DONE;
                    end else begin
                        head_reg  <= head_reg + PCW'(1);
                        state_reg <= S_POP_EV;
                    end
                end
                S_POP_EV: begin
                    cur_reg   <= l_rdata;
                    cand_reg  <= '0;
                    state_reg <= S_NB_RD;
                end
                S_NB_RD: begin
                    op_addr_reg <= nb_addr;
                    goal_reg    <= nb.goal;
                    if (nb.done) begin
                        state_reg <= S_POP_RD;
                    end else if (nb.ok) begin
                        state_reg <= S_NB_EV;
                    end else begin
                        cand_reg <= cand_reg + CANDW'(1);
                    end
                end
                S_NB_EV: begin
                    cand_reg  <= cand_reg + CANDW'(1);
                    state_reg <= S_NB_RD;
                    if (claim) begin
                        if (goal_reg) begin
                            walk_reg  <= op_addr_reg;
                            k_reg     <= '0;
                            state_reg <= S_WALK_RD;
                        end else begin
                            tail_reg <= tail_reg + PCW'(1);
                        end
                    end
                end
                S_WALK_RD: begin
                    state_reg <= S_WALK_EV;
                end
                S_WALK_EV: begin
                    if (rd_parent == '0) begin
                        path_count_reg <= PCW'(k_reg) + PCW'(1);
                        state_reg      <= S_DONE;
                    end else begin
                        walk_reg  <= AW'(rd_parent - PCW'(1));
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= S_WALK_RD;
                    end
                end
                S_PATH_EV: begin
                    res_x_reg <= 7'(l_rdata[CW-1:0]);
                    res_y_reg <= 7'(l_rdata[2*CW-1:CW]);
                    res_l_reg <= 2'(l_rdata[AW-1:2*CW]);
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_len_reg    <= 17'(path_count_reg);
                        m_x_reg      <= res_x_reg;
                        m_y_reg      <= res_y_reg;
                        m_l_reg      <= res_l_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_path_length = m_len_reg;
    assign m_out_x       = m_x_reg;
    assign m_out_y       = m_y_reg;
    assign m_out_layer   = m_l_reg;

    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg)
        else $error("frontier head passed tail");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(path_count_reg) <= GRID_DIM * GRID_DIM * MAX_LAYERS)
        else $error("path count beyond cell count");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_path_length)
            && $stable(m_out_x) && $stable(m_out_y) && $stable(m_out_layer))
        else $error("result changed while waiting");

endmodule

/* hw/rtl/lmr_ram.sv */
// lmr_ram: simple dual-port synchronous ram, one write and one read port,
// registered read data that holds when no read is issued; no dependencies
module lmr_ram #(
    parameter int WIDTH = 8,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/lmr_nbr.sv */
// lmr_nbr: forms the address of one expansion candidate (eight planar steps,
// then vias in layer order) and checks it against the grid; uses lmr_pkg
module lmr_nbr #(
    parameter int CW = 7,
    parameter int LW = 2,
    parameter int LCW = 3,
    parameter int CANDW = 4
) (
    input  logic [CW-1:0]       cur_x,
    input  logic [CW-1:0]       cur_y,
    input  logic [LW-1:0]       cur_l,
    input  logic [CW-1:0]       goal_x,
    input  logic [CW-1:0]       goal_y,
    input  logic [CANDW-1:0]    cand,
    input  logic [CW:0]         w_eff,
    input  logic [CW:0]         h_eff,
    input  logic [LCW-1:0]      l_eff,
    output lmr_pkg::nbr_t       nb,
    output logic [LW+2*CW-1:0]  nb_addr
);

    logic [CW:0]       nx;
    logic [CW:0]       ny;
    logic [CANDW-1:0]  lidx;
    logic              planar;

    always_comb begin
        planar = (32'(cand) < 8);
        // stepping below zero wraps to all ones, which fails the bound check
        nx = {1'b0, cur_x} + (CW+1)'(lmr_pkg::step_dx(cand[2:0]));
        ny = {1'b0, cur_y} + (CW+1)'(lmr_pkg::step_dy(cand[2:0]));
        lidx = cand - CANDW'(8);
        nb.done = (32'(cand) >= 32'(l_eff) + 8);
        if (planar) begin
            nb.ok   = (nx < w_eff) && (ny < h_eff);
            nb.goal = (nx[CW-1:0] == goal_x) && (ny[CW-1:0] == goal_y);
            nb_addr = {cur_l, ny[CW-1:0], nx[CW-1:0]};
        end else begin
            nb.ok   = (32'(lidx) < 32'(l_eff)) && (LW'(lidx) != cur_l);
            nb.goal = (cur_x == goal_x) && (cur_y == goal_y);
            nb_addr = {LW'(lidx), cur_y, cur_x};
        end
    end

endmodule

/* tb/sv/layered_maze_router_unit_tb.sv */
// layered_maze_router_unit_tb: self-checking bench for the layered maze router;
// a directed table, then random phases per grid setting, checked against an
// in-bench breadth-first predictor; depends on lmr_pkg and the router rtl
`timescale 1ns / 100ps

module layered_maze_router_unit_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PLANE = 128 * 128;
    localparam int CELLS = PLANE * 4;
    localparam int DX[8] = '{1, -1, 0, 0, 1, 1, -1, -1};
    localparam int DY[8] = '{0, 0, 1, -1, 1, -1, 1, -1};

    typedef struct {
        logic [1:0]  cmd;
        logic [1:0]  lay;
        logic [6:0]  x;
        logic [6:0]  y;
        logic        blk;
        logic [6:0]  gx;
        logic [6:0]  gy;
        logic [15:0] idx;
    } req_t;

    typedef struct {
        logic [1:0]  status;
        logic [16:0] len;
        logic [6:0]  ox;
        logic [6:0]  oy;
        logic [1:0]  ol;
    } res_t;

    typedef struct {
        bit         is_cfg;
        logic [7:0] cw;
        logic [7:0] ch;
        logic [2:0] cl;
        req_t       it;
        bit         typed;
        res_t       want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [1:0]  s_layer_sel;
    logic [6:0]  s_cell_x;
    logic [6:0]  s_cell_y;
    logic        s_blocked;
    logic [6:0]  s_goal_x;
    logic [6:0]  s_goal_y;
    logic [15:0] s_path_index;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [16:0] m_path_length;
    logic [6:0]  m_out_x;
    logic [6:0]  m_out_y;
    logic [1:0]  m_out_layer;

    layered_maze_router_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_layer_sel(s_layer_sel), .s_cell_x(s_cell_x), .s_cell_y(s_cell_y),
        .s_blocked(s_blocked), .s_goal_x(s_goal_x), .s_goal_y(s_goal_y),
        .s_path_index(s_path_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_path_length(m_path_length), .m_out_x(m_out_x), .m_out_y(m_out_y),
        .m_out_layer(m_out_layer)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // router shadow state
    bit          obst_map[CELLS];
    bit          seen_map[CELLS];
    int unsigned back_link[CELLS];
    int unsigned wave[CELLS];
    int unsigned trail[CELLS];
    int unsigned trail_len;
    logic [7:0]  reg_w;
    logic [7:0]  reg_h;
    logic [2:0]  reg_l;

    res_t awaited_results[$];
    row_t plan[$];
    int   errors;
    bit   idle_on;
    int   ready_hold;

    function automatic int clamp(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int cell_of(input int x, input int y, input int l);
        return (l * 128 + y) * 128 + x;
    endfunction

    // breadth-first search; returns the route status and leaves the path in trail
    function automatic logic [1:0] search_path(input int sx, input int sy,
                                               input int gx, input int gy);
        int w, h, layers, head, tail, goal, c, cur, cx, cy, cl, nx, ny, n, k;
        bit same, found, at_goal;
        w = clamp(int'(reg_w), 128);
        h = clamp(int'(reg_h), 128);
        layers = clamp(int'(reg_l), 4);
        head = 0;
        tail = 0;
        trail_len = 0;
        if (sx >= w || sy >= h || gx >= w || gy >= h) return lmr_pkg::STATUS_NO_PATH;
        seen_map = '{default: 1'b0};
        same = (sx == gx) && (sy == gy);
        for (int l = 0; l < layers; l++) begin
            c = cell_of(sx, sy, l);
            if (obst_map[c] && !same) continue;
            seen_map[c] = 1'b1;
            back_link[c] = 0;
            wave[tail++] = c;
        end
        found = same;
        goal = cell_of(gx, gy, 0);
        while (!found && head < tail) begin
            cur = wave[head++];
            cx = cur % 128;
            cy = (cur / 128) % 128;
            cl = cur / PLANE;
            for (int d = 0; d < 8 && !found; d++) begin
                nx = cx + DX[d];
                ny = cy + DY[d];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                at_goal = (nx == gx) && (ny == gy);
                n = cell_of(nx, ny, cl);
                if (!seen_map[n] && (!obst_map[n] || at_goal)) begin
                    seen_map[n] = 1'b1;
                    back_link[n] = cur + 1;
                    if (at_goal) begin
                        found = 1'b1;
                        goal = n;
                    end else begin
                        wave[tail++] = n;
                    end
                end
            end
            // vias to the other layers at the same column and row
            for (int l = 0; l < layers && !found; l++) begin
                at_goal = (cx == gx) && (cy == gy);
                if (l == cl) continue;
                n = cell_of(cx, cy, l);
                if (!seen_map[n] && (!obst_map[n] || at_goal)) begin
                    seen_map[n] = 1'b1;
                    back_link[n] = cur + 1;
                    if (at_goal) begin
                        found = 1'b1;
                        goal = n;
                    end else begin
                        wave[tail++] = n;
                    end
                end
            end
        end
        if (!found) return lmr_pkg::STATUS_NO_PATH;
        n = 1;
        c = goal;
        while (back_link[c] != 0) begin
            c = back_link[c] - 1;
            n++;
        end
        c = goal;
        for (k = 0; k < n; k++) begin
            trail[n - 1 - k] = c;
            if (back_link[c] != 0) c = back_link[c] - 1;
        end
        trail_len = n;
        return lmr_pkg::STATUS_OK;
    endfunction

    function automatic res_t compute_router_result(input req_t it);
        res_t r;
        int unsigned c;
        r = '{lmr_pkg::STATUS_OK, 17'd0, 7'd0, 7'd0, 2'd0};
        case (it.cmd)
            lmr_pkg::CMD_WRITE:
                obst_map[cell_of(int'(it.x), int'(it.y), int'(it.lay))] = it.blk;
            lmr_pkg::CMD_ROUTE:
                r.status = search_path(int'(it.x), int'(it.y), int'(it.gx), int'(it.gy));
            lmr_pkg::CMD_READ: begin
                if (trail_len == 0) begin
                    r.status = lmr_pkg::STATUS_NO_PATH;
                end else if (it.idx >= trail_len) begin
                    r.status = lmr_pkg::STATUS_RANGE;
                end else begin
                    c = trail[it.idx];
                    r.ox = 7'(c % 128);
                    r.oy = 7'((c / 128) % 128);
                    r.ol = 2'(c / PLANE);
                end
            end
            default: ;
        endcase
        r.len = 17'(trail_len);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic req_t mk(input logic [1:0] cmd, input int lay,
                                input int x, input int y, input int blk,
                                input int gx, input int gy, input int idx);
        req_t it;
        it = '{cmd, lay[1:0], x[6:0], y[6:0], blk[0], gx[6:0], gy[6:0], idx[15:0]};
        return it;
    endfunction

    task automatic add_item(input req_t it, input bit typed, input res_t want);
        row_t r;
        r = '{1'b0, 8'd0, 8'd0, 3'd0, it, typed, want};
        plan.insert(plan.size(), r);
    endtask

    task automatic add_cfg(input int w, input int h, input int l);
        row_t r;
        r = '{1'b1, w[7:0], h[7:0], l[2:0], mk(lmr_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 0, 0),
              1'b0, '{lmr_pkg::STATUS_OK, 17'd0, 7'd0, 7'd0, 2'd0}};
        plan.insert(plan.size(), r);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_config(input logic [7:0] w, input logic [7:0] h,
                                input logic [2:0] l);
        drain_results();
        // routes give a result per item, so a short settle is enough
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= lmr_pkg::CFG_GRID_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= lmr_pkg::CFG_GRID_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_index <= lmr_pkg::CFG_LAYER_COUNT;
        cfg_wdata <= {5'd0, l};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        reg_w = w;
        reg_h = h;
        reg_l = l;
    endtask

    task automatic send_item(input req_t it, input bit typed, input res_t want);
        int g;
        res_t r;
        g = pick_gap();
        @(negedge aclk);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= it.cmd;
        s_layer_sel  <= it.lay;
        s_cell_x     <= it.x;
        s_cell_y     <= it.y;
        s_blocked    <= it.blk;
        s_goal_x     <= it.gx;
        s_goal_y     <= it.gy;
        s_path_index <= it.idx;
        do @(posedge aclk); while (!s_ready);
        r = compute_router_result(it);
        awaited_results.insert(awaited_results.size(), typed ? want : r);
    endtask

    function automatic req_t random_item(input bit wide_grid);
        req_t it;
        int w, h, r, lo, hi;
        w = clamp(int'(reg_w), 128);
        h = clamp(int'(reg_h), 128);
        it = mk(2'($urandom_range(3)), $urandom_range(3), $urandom_range(127),
                $urandom_range(127), $urandom_range(1), $urandom_range(127),
                $urandom_range(127), $urandom_range(65535));
        r = $urandom_range(99);
        if (r < 35) begin
            it.cmd = lmr_pkg::CMD_WRITE;
            it.blk = ($urandom_range(99) < 30);
            if ($urandom_range(9) != 0) begin
                it.x = 7'($urandom_range(w > 15 ? 16 : w));
                it.y = 7'($urandom_range(h > 15 ? 16 : h));
            end
        end else if (r < 65) begin
            it.cmd = lmr_pkg::CMD_ROUTE;
            if (wide_grid) begin
                // keep big-grid searches short: start clear of the dense corner
                it.x = 7'($urandom_range(64, 127));
                it.y = 7'($urandom_range(64, 127));
                lo = int'(it.x) - 3;
                hi = int'(it.x) + 3;
                it.gx = 7'($urandom_range(lo < 64 ? 64 : lo, hi > 127 ? 127 : hi));
                lo = int'(it.y) - 3;
                hi = int'(it.y) + 3;
                it.gy = 7'($urandom_range(lo < 64 ? 64 : lo, hi > 127 ? 127 : hi));
            end else begin
                it.x  = 7'($urandom_range(w > 127 ? 127 : w));
                it.y  = 7'($urandom_range(h > 127 ? 127 : h));
                it.gx = 7'($urandom_range(w > 127 ? 127 : w));
                it.gy = 7'($urandom_range(h > 127 ? 127 : h));
            end
        end else if (r < 95) begin
            it.cmd = lmr_pkg::CMD_READ;
            if (trail_len > 0 && $urandom_range(9) < 8) it.idx = 16'($urandom_range(trail_len));
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    // result side: random stalls, checked on every transfer
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                e = awaited_results.pop_front();
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status);
                    errors++;
                end
                if (m_path_length !== e.len) begin
                    $error("path_length: expected %0d, got %0d", e.len, m_path_length);
                    errors++;
                end
                if (m_out_x !== e.ox) begin
                    $error("out_x: expected %0d, got %0d", e.ox, m_out_x);
                    errors++;
                end
                if (m_out_y !== e.oy) begin
                    $error("out_y: expected %0d, got %0d", e.oy, m_out_y);
                    errors++;
                end
                if (m_out_layer !== e.ol) begin
                    $error("out_layer: expected %0d, got %0d", e.ol, m_out_layer);
                    errors++;
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        res_t none, ok0, nop;
        logic [7:0] pw[8];
        logic [7:0] ph[8];
        logic [2:0] pl[8];
        errors = 0;
        idle_on = 1'b1;
        ready_hold = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = lmr_pkg::CFG_GRID_WIDTH;
        cfg_wdata = 8'd0;
        s_valid = 1'b0;
        s_cmd = lmr_pkg::CMD_WRITE;
        s_layer_sel = 2'd0;
        s_cell_x = 7'd0;
        s_cell_y = 7'd0;
        s_blocked = 1'b0;
        s_goal_x = 7'd0;
        s_goal_y = 7'd0;
        s_path_index = 16'd0;
        m_ready = 1'b0;
        obst_map = '{default: 1'b0};
        trail_len = 0;
        reg_w = lmr_pkg::GRID_WIDTH_RST;
        reg_h = lmr_pkg::GRID_HEIGHT_RST;
        reg_l = lmr_pkg::LAYER_COUNT_RST;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        none = '{lmr_pkg::STATUS_OK, 17'd0, 7'd0, 7'd0, 2'd0};
        ok0  = none;
        nop  = '{lmr_pkg::STATUS_NO_PATH, 17'd0, 7'd0, 7'd0, 2'd0};
        add_item(mk(lmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1, nop);
        add_item(mk(lmr_pkg::CMD_WRITE, 3, 127, 127, 1, 0, 0, 0), 1, ok0);
        add_item(mk(CMD_UNUSED, 3, 127, 127, 1, 127, 127, 65535), 1, ok0);
        // start on goal: one cell on layer 0
        add_item(mk(lmr_pkg::CMD_ROUTE, 0, 0, 0, 0, 0, 0, 0), 1,
                 '{lmr_pkg::STATUS_OK, 17'd1, 7'd0, 7'd0, 2'd0});
        add_item(mk(lmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1,
                 '{lmr_pkg::STATUS_OK, 17'd1, 7'd0, 7'd0, 2'd0});
        add_item(mk(lmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1), 1,
                 '{lmr_pkg::STATUS_RANGE, 17'd1, 7'd0, 7'd0, 2'd0});
        add_item(mk(lmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 65535), 1,
                 '{lmr_pkg::STATUS_RANGE, 17'd1, 7'd0, 7'd0, 2'd0});
        // blocked goal is still reachable
        add_item(mk(lmr_pkg::CMD_WRITE, 0, 1, 0, 1, 0, 0, 0), 0, none);
        add_item(mk(lmr_pkg::CMD_ROUTE, 0, 0, 0, 0, 1, 0, 0), 0, none);
        add_item(mk(lmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1), 0, none);
        // blocked start on the only layer
        add_item(mk(lmr_pkg::CMD_WRITE, 0, 5, 5, 1, 0, 0, 0), 0, none);
        add_item(mk(lmr_pkg::CMD_ROUTE, 0, 5, 5, 0, 9, 9, 0), 1, nop);
        add_item(mk(lmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1, nop);
        add_item(mk(lmr_pkg::CMD_ROUTE, 0, 127, 127, 0, 125, 126, 0), 0, none);
        add_item(mk(lmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 2), 0, none);
        add_item(mk(lmr_pkg::CMD_WRITE, 0, 5, 5, 0, 0, 0, 0), 0, none);
        add_cfg(4, 3, 4);
        add_item(mk(lmr_pkg::CMD_ROUTE, 0, 4, 0, 0, 0, 0, 0), 1, nop);
        add_item(mk(lmr_pkg::CMD_ROUTE, 0, 0, 0, 0, 3, 3, 0), 1, nop);
        // wall across layer 0 keeps the path on another layer
        add_item(mk(lmr_pkg::CMD_WRITE, 0, 1, 1, 1, 0, 0, 0), 0, none);
        add_item(mk(lmr_pkg::CMD_WRITE, 0, 1, 2, 1, 0, 0, 0), 0, none);
        add_item(mk(lmr_pkg::CMD_ROUTE, 0, 0, 0, 0, 2, 0, 0), 0, none);
        add_item(mk(lmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1), 0, none);
        add_item(mk(lmr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 2), 0, none);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_config(plan[i].cw, plan[i].ch, plan[i].cl);
            else send_item(plan[i].it, plan[i].typed, plan[i].want);
        end

        // register extremes: 0 and 255 clamp, 7 layers clamps to four
        pw = '{8'd8, 8'd1, 8'd0, 8'd6, 8'd255, 8'd3, 8'd128, 8'd16};
        ph = '{8'd8, 8'd1, 8'd255, 8'd6, 8'd1, 8'd7, 8'd128, 8'd4};
        pl = '{3'd2, 3'd1, 3'd7, 3'd4, 3'd0, 3'd3, 3'd1, 3'd4};
        for (int p = 0; p < 8; p++) begin
            write_config(pw[p], ph[p], pl[p]);
            idle_on = (p != 1);
            for (int i = 0; i < 135; i++) begin
                if ($urandom_range(199) == 0) drain_results();
                send_item(random_item(p == 6), 0, none);
            end
        end
        idle_on = 1'b1;
        drain_results();
        repeat (50) @(posedge aclk);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
